// ----- rtl/rmwm_pkg.sv -----
// ----------------------------------------------------------------------------
// rmwm_pkg: shared types, constants and arithmetic helpers
// Window and pixel types, group sizes and the constant-divide and small sort
// functions used by the front end and the filter pipeline.
// ----------------------------------------------------------------------------
package rmwm_pkg;

	localparam int CHAN_W      = 8;
	localparam int NUM_CHAN    = 3;
	localparam int ROW_LEN     = 3;
	localparam int WIN_SIZE    = ROW_LEN * ROW_LEN;
	localparam int CENTRE      = WIN_SIZE / 2;
	localparam int CNT_W       = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUOT_W      = 5;   // floor(255 / 10) = 25
	localparam int HALF_W      = 6;   // floor(255 / 5)  = 51

	// last pixel index of a full-window group and of a column group
	localparam logic [CNT_W-1:0] FULL_LAST = CNT_W'(WIN_SIZE - 1);
	localparam logic [CNT_W-1:0] COL_LAST  = CNT_W'(ROW_LEN - 1);

	// reciprocal multiplier: x * 205 >> 11 == x / 10 for x < 1029
	localparam logic [CHAN_W-1:0] DIV_MULT = 8'd205;

	typedef logic [CHAN_W-1:0] chan_t;
	// index 2 = red, 1 = green, 0 = blue
	typedef chan_t [NUM_CHAN-1:0] pixel_t;
	// row-major, index 0 = top left
	typedef pixel_t [WIN_SIZE-1:0] window_t;

	typedef logic [QUOT_W-1:0] quot_t;

	typedef struct packed {
		chan_t lo;
		chan_t mid;
		chan_t hi;
	} sort3_t;

	// floor(v / 10)
	function automatic quot_t div10(input chan_t v);
		logic [2*CHAN_W-1:0] prod;
		prod = (2*CHAN_W)'(v) * (2*CHAN_W)'(DIV_MULT);
		return prod[2*CHAN_W-1 -: QUOT_W];
	endfunction

	// floor(2 * v / 10) == floor(v / 5)
	function automatic logic [HALF_W-1:0] div5(input chan_t v);
		logic [2*CHAN_W-1:0] prod;
		prod = (2*CHAN_W)'(v) * (2*CHAN_W)'(DIV_MULT);
		return prod[2*CHAN_W-1 -: HALF_W];
	endfunction

	// three-element sorting network
	function automatic sort3_t sort3(input chan_t a, input chan_t b, input chan_t c);
		chan_t  x0, x1, y1, y2;
		sort3_t s;
		x0 = (a < b) ? a : b;
		x1 = (a < b) ? b : a;
		y1 = (x1 < c) ? x1 : c;
		y2 = (x1 < c) ? c : x1;
		s.lo  = (x0 < y1) ? x0 : y1;
		s.mid = (x0 < y1) ? y1 : x0;
		s.hi  = y2;
		return s;
	endfunction

	function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
		sort3_t s;
		s = sort3(a, b, c);
		return s.mid;
	endfunction

	function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
		chan_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
		chan_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

endpackage

// ----- rtl/rmwm_if.sv -----
// ----------------------------------------------------------------------------
// rmwm_if: stream channels of the filter
// Pixel input channel and filtered result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmwm_pixel_if;
	logic                  valid;
	logic                  ready;
	rmwm_pkg::chan_t       red;
	rmwm_pkg::chan_t       green;
	rmwm_pkg::chan_t       blue;
	logic                  window_start;

	modport source (output valid, output red, output green, output blue,
		output window_start, input ready);
	modport sink (input valid, input red, input green, input blue,
		input window_start, output ready);
endinterface

interface rmwm_result_if;
	logic                  valid;
	logic                  ready;
	rmwm_pkg::chan_t       out_red;
	rmwm_pkg::chan_t       out_green;
	rmwm_pkg::chan_t       out_blue;

	modport source (output valid, output out_red, output out_green,
		output out_blue, input ready);
	modport sink (input valid, input out_red, input out_green,
		input out_blue, output ready);
endinterface

// ----- rtl/rmwm_front.sv -----
// ----------------------------------------------------------------------------
// rmwm_front: pixel intake and window update
// Accepts pixels, tracks group progress and keeps the raw 3x3 window. On the
// pixel that completes a group it hands a snapshot of the window downstream.
// ----------------------------------------------------------------------------
module rmwm_front (
	input  logic                clk,
	input  logic                arst_n,
	rmwm_pixel_if.sink          pixel,
	input  logic                queue_full,
	output logic                push,
	output rmwm_pkg::window_t   push_data
);

	rmwm_pkg::window_t            win_q;
	rmwm_pkg::window_t            win_next;
	logic [rmwm_pkg::CNT_W-1:0]   gathered_q;
	logic                         full_q;
	logic                         full_now;
	logic                         last;
	logic                         accept;
	rmwm_pkg::pixel_t             pix;

	assign pixel.ready = !queue_full;
	assign accept      = pixel.valid && pixel.ready;
	assign pix         = {pixel.red, pixel.green, pixel.blue};

	// group kind comes from the first pixel of the group only
	assign full_now = (gathered_q == '0) ? pixel.window_start : full_q;
	assign last     = full_now ? (gathered_q == rmwm_pkg::FULL_LAST)
	                           : (gathered_q == rmwm_pkg::COL_LAST);

	// window after this pixel: direct load, or shift one row left
	always_comb begin
		win_next = win_q;
		if (full_now) begin
			win_next[gathered_q] = pix;
		end else begin
			for (int r = 0; r < rmwm_pkg::ROW_LEN; r++) begin
				if (gathered_q == rmwm_pkg::CNT_W'(r)) begin
					win_next[r*rmwm_pkg::ROW_LEN]     = win_q[r*rmwm_pkg::ROW_LEN + 1];
					win_next[r*rmwm_pkg::ROW_LEN + 1] = win_q[r*rmwm_pkg::ROW_LEN + 2];
					win_next[r*rmwm_pkg::ROW_LEN + 2] = pix;
				end
			end
		end
	end

	assign push      = accept && last;
	assign push_data = win_next;

	// group state and kept window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			gathered_q <= '0;
			full_q     <= 1'b0;
		end else if (accept) begin
			win_q      <= win_next;
			full_q     <= full_now;
			gathered_q <= last ? '0 : gathered_q + 1'b1;
		end
	end

endmodule

// ----- rtl/rmwm_queue.sv -----
// ----------------------------------------------------------------------------
// rmwm_queue: window snapshot queue
// Short FIFO between the front end and the filter pipeline so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module rmwm_queue #(
	parameter int DEPTH = rmwm_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rmwm_pkg::window_t   push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output rmwm_pkg::window_t   pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rmwm_pkg::window_t   mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/rmwm_back.sv -----
// ----------------------------------------------------------------------------
// rmwm_back: median and weighted mean pipeline
// Three stages: row sort and side-term divide, column reduce and sum, then
// the final median with the centre term into the output register.
// ----------------------------------------------------------------------------
module rmwm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rmwm_pkg::window_t   in_data,
	output logic                pop,
	rmwm_result_if.source       result
);

	localparam int NC = rmwm_pkg::NUM_CHAN;
	localparam int RL = rmwm_pkg::ROW_LEN;
	localparam int WS = rmwm_pkg::WIN_SIZE;

	logic                                   en;
	logic                                   valid_s1, valid_s2, valid_s3;
	rmwm_pkg::sort3_t [NC-1:0][RL-1:0]      rows_s1, rows_d;
	rmwm_pkg::quot_t  [NC-1:0][WS-1:0]      quot_s1, quot_d;
	rmwm_pkg::sort3_t [NC-1:0]              col_s2, col_d;
	rmwm_pkg::chan_t  [NC-1:0]              sum_s2, sum_d;
	rmwm_pkg::chan_t  [NC-1:0]              res_s3, res_d;

	// pipeline advances unless the output item is stalled
	assign en  = !(result.valid && !result.ready);
	assign pop = en && in_valid;

	// stage 1: sort each row, divide the side pixels by ten
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			for (int r = 0; r < RL; r++) begin
				rows_d[c][r] = rmwm_pkg::sort3(in_data[r*RL][c], in_data[r*RL + 1][c],
					in_data[r*RL + 2][c]);
			end
			for (int i = 0; i < WS; i++) begin
				quot_d[c][i] = (i == rmwm_pkg::CENTRE) ? '0 : rmwm_pkg::div10(in_data[i][c]);
			end
		end
	end

	// stage 2: column reduce of the sorted rows, sum of side terms
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			col_d[c].lo  = rmwm_pkg::max3(rows_s1[c][0].lo, rows_s1[c][1].lo,
				rows_s1[c][2].lo);
			col_d[c].mid = rmwm_pkg::med3(rows_s1[c][0].mid, rows_s1[c][1].mid,
				rows_s1[c][2].mid);
			col_d[c].hi  = rmwm_pkg::min3(rows_s1[c][0].hi, rows_s1[c][1].hi,
				rows_s1[c][2].hi);
			sum_d[c] = '0;
			for (int i = 0; i < WS; i++) begin
				sum_d[c] = sum_d[c] + rmwm_pkg::CHAN_W'(quot_s1[c][i]);
			end
		end
	end

	// stage 3: median of the window, doubled centre term added
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			res_d[c] = sum_s2[c] + rmwm_pkg::CHAN_W'(rmwm_pkg::div5(
				rmwm_pkg::med3(col_s2[c].lo, col_s2[c].mid, col_s2[c].hi)));
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			rows_s1 <= rows_d;
			quot_s1 <= quot_d;
			col_s2  <= col_d;
			sum_s2  <= sum_d;
			res_s3  <= res_d;
		end
	end

	assign result.valid     = valid_s3;
	assign result.out_red   = res_s3[2];
	assign result.out_green = res_s3[1];
	assign result.out_blue  = res_s3[0];

endmodule

// ----- rtl/rgb_median_then_weighted_mean_3x3_top.sv -----
// The last pixel of a group (three pixels for a column group, nine for a full
//   one) pushes its window into the snapshot queue, then the pipeline stages.
// Throughput: a pixel per cycle while the queue has room, a result per group.
// Input stalls only when the snapshot queue is full behind a stalled output.
// Reset (arst_n low, asynchronous) zeroes the window and group count and
//   empties the queue and pipeline.
// ----------------------------------------------------------------------------
// rgb_median_then_weighted_mean_3x3_top: 3x3 RGB median then weighted mean
// Front end builds the window, a short queue decouples it from the filter
// pipeline that drives the result channel.
// ----------------------------------------------------------------------------
module rgb_median_then_weighted_mean_3x3_top #(
	parameter int QUEUE_DEPTH = rmwm_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	rmwm_pixel_if.sink      pixel,
	rmwm_result_if.source   result
);

	logic                 push;
	rmwm_pkg::window_t    push_data;
	logic                 queue_full;
	logic                 queue_pop;
	logic                 queue_valid;
	rmwm_pkg::window_t    queue_data;

	// pixel intake
	rmwm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	// window snapshot queue
	rmwm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_valid),
		.pop_data  (queue_data)
	);

	// filter pipeline
	rmwm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (queue_valid),
		.in_data  (queue_data),
		.pop      (queue_pop),
		.result   (result)
	);

endmodule

// ----- rtl/rmwm_checker.sv -----
// ----------------------------------------------------------------------------
// rmwm_checker: port-level checks of the filter
// Watches the result channel for hold under stall, value range and reset.
// ----------------------------------------------------------------------------
module rmwm_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              result_valid,
	input  logic              result_ready,
	input  rmwm_pkg::chan_t   out_red,
	input  rmwm_pkg::chan_t   out_green,
	input  rmwm_pkg::chan_t   out_blue
);

	localparam rmwm_pkg::chan_t MAX_OUT = 8'd251;

	// a stalled item stays and keeps its values
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(out_red) &&
			$stable(out_green) && $stable(out_blue))
		else $error("result item changed while stalled");

	// weighted mean cannot exceed its ceiling
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> out_red <= MAX_OUT && out_green <= MAX_OUT &&
			out_blue <= MAX_OUT)
		else $error("result value out of range");

	// no item is offered while in reset
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind rgb_median_then_weighted_mean_3x3_top rmwm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.out_red      (result.out_red),
	.out_green    (result.out_green),
	.out_blue     (result.out_blue)
);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for the 3x3 RGB median then weighted mean filter
// Drives pixel groups (nine-pixel full windows and three-pixel columns) into
// the block and predicts each filtered result. The prediction keeps its own
// window, sorts each channel for the median and forms the weighted sum.
// Directed cases come first, then random groups under random idling on both
// channels, a long output hold-off that fills the block, and a final
// stretch at full rate.
// ----------------------------------------------------------------------------
module tb;

	localparam int LAT_CYCLES    = 3;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DIVISOR       = 10;
	localparam int CENTRE_WEIGHT = 2;
	localparam int HOLD_LEN      = 80;

	typedef struct packed {
		rmwm_pkg::chan_t red;
		rmwm_pkg::chan_t green;
		rmwm_pkg::chan_t blue;
	} rgb_t;

	// one channel of the window, row-major
	typedef rmwm_pkg::chan_t [rmwm_pkg::WIN_SIZE-1:0] plane_t;

	logic clk;
	logic arst_n;

	rmwm_pixel_if  pix_if ();
	rmwm_result_if res_if ();

	rgb_median_then_weighted_mean_3x3_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_if),
		.result (res_if)
	);

	// predicted window state
	rgb_t        win_pred [rmwm_pkg::WIN_SIZE];
	int unsigned gathered_pred;
	logic        full_grp_pred;

	rgb_t        filt_expected [$];
	int unsigned n_errors   = 0;
	int unsigned n_cycles   = 0;
	int unsigned n_sent     = 0;
	bit          src_idle_en = 1'b0;
	bit          snk_idle_en = 1'b0;
	int unsigned hold_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// median of one channel, then sum of truncated weighted terms
	function automatic rmwm_pkg::chan_t filter_chan(plane_t v);
		plane_t          srt;
		rmwm_pkg::chan_t t;
		int              j;
		int unsigned     acc;
		srt = v;
		for (int i = 1; i < rmwm_pkg::WIN_SIZE; i++) begin
			t = srt[i];
			j = i;
			while (j > 0 && srt[j-1] > t) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = t;
		end
		acc = 0;
		for (int i = 0; i < rmwm_pkg::WIN_SIZE; i++) begin
			if (i == rmwm_pkg::CENTRE)
				acc += (CENTRE_WEIGHT * int'(srt[rmwm_pkg::CENTRE])) / DIVISOR;
			else
				acc += int'(v[i]) / DIVISOR;
		end
		return rmwm_pkg::chan_t'(acc);
	endfunction

	// fold one accepted pixel into the predicted window
	function automatic void absorb_pixel(rgb_t px, logic start);
		int unsigned need;
		int unsigned k;
		int unsigned b;
		plane_t      pr, pg, pb;
		if (gathered_pred == 0)
			full_grp_pred = start;
		k    = gathered_pred;
		need = full_grp_pred ? rmwm_pkg::WIN_SIZE : rmwm_pkg::ROW_LEN;
		if (full_grp_pred) begin
			win_pred[k] = px;
		end else begin
			// shift row k left, new pixel enters on the right
			b = k * rmwm_pkg::ROW_LEN;
			win_pred[b]   = win_pred[b+1];
			win_pred[b+1] = win_pred[b+2];
			win_pred[b+2] = px;
		end
		k++;
		if (k < need) begin
			gathered_pred = k;
			return;
		end
		gathered_pred = 0;
		for (int i = 0; i < rmwm_pkg::WIN_SIZE; i++) begin
			pr[i] = win_pred[i].red;
			pg[i] = win_pred[i].green;
			pb[i] = win_pred[i].blue;
		end
		filt_expected.push_back(rgb_t'{filter_chan(pr), filter_chan(pg), filter_chan(pb)});
	endfunction

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		$display("MISMATCH cycle %0d: %s expected %0d got %0d", n_cycles, what, want, got);
		n_errors++;
	endtask

	// offer one pixel, wait for the handshake, then predict
	task automatic send_pixel(rmwm_pkg::chan_t r, rmwm_pkg::chan_t g, rmwm_pkg::chan_t b,
		logic start);
		int unsigned gap;
		gap = 0;
		if (src_idle_en && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 7);
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid        <= 1'b1;
		pix_if.red          <= r;
		pix_if.green        <= g;
		pix_if.blue         <= b;
		pix_if.window_start <= start;
		do @(posedge clk); while (!pix_if.ready);
		absorb_pixel(rgb_t'{r, g, b}, start);
		n_sent++;
	endtask

	// mix of extremes, small values (many ties) and uniform values
	function automatic rmwm_pkg::chan_t rand_chan();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			2, 3:    return rmwm_pkg::chan_t'($urandom_range(0, 15));
			default: return rmwm_pkg::chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	// one well-formed group; later pixels sometimes carry the other flag
	task automatic send_random_group();
		logic        start;
		logic        flag;
		int unsigned n;
		start = ($urandom_range(0, 3) == 0);
		n     = start ? rmwm_pkg::WIN_SIZE : rmwm_pkg::ROW_LEN;
		for (int i = 0; i < n; i++) begin
			flag = start;
			if (i != 0 && $urandom_range(0, 7) == 0)
				flag = ~start;
			send_pixel(rand_chan(), rand_chan(), rand_chan(), flag);
		end
	endtask

	task automatic send_random_items(int unsigned count);
		int unsigned base;
		base = n_sent;
		while (n_sent - base < count)
			send_random_group();
	endtask

	// column group right after reset shifts into a zero window
	task automatic test_column_before_full_window();
		send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
	endtask

	// all-255 window gives the largest result; later flags of 0 are ignored
	task automatic test_full_window_max();
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		for (int i = 1; i < rmwm_pkg::WIN_SIZE; i++)
			send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
	endtask

	// column group whose later pixels carry a start flag, then a mixed column
	task automatic test_column_flags_ignored();
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd1, 8'd128, 8'd254, 1'b0);
		send_pixel(8'd127, 8'd85, 8'd170, 1'b0);
		send_pixel(8'd9, 8'd10, 8'd11, 1'b0);
	endtask

	task automatic test_random_with_idling(int unsigned count);
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		send_random_items(count);
	endtask

	// output held off long enough that the block must stall its input
	task automatic test_output_backpressure();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		hold_cycles = HOLD_LEN;
		send_random_items(40);
	endtask

	task automatic test_random_full_rate(int unsigned count);
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		send_random_items(count);
	endtask

	// result receiver: hold-off, random stall bursts, otherwise ready
	initial begin
		int unsigned burst;
		burst        = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_if.ready <= 1'b0;
				hold_cycles--;
			end else if (burst > 0) begin
				res_if.ready <= 1'b0;
				burst--;
			end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
				res_if.ready <= 1'b0;
				burst = $urandom_range(0, 6);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (filt_expected.size() == 0) begin
				report_mismatch("result with nothing pending, red", 0, res_if.out_red);
			end else begin
				want = filt_expected.pop_front();
				if (res_if.out_red !== want.red)
					report_mismatch("out_red", want.red, res_if.out_red);
				if (res_if.out_green !== want.green)
					report_mismatch("out_green", want.green, res_if.out_green);
				if (res_if.out_blue !== want.blue)
					report_mismatch("out_blue", want.blue, res_if.out_blue);
			end
		end
	end

	// main sequence
	initial begin
		arst_n              = 1'b0;
		pix_if.valid        = 1'b0;
		pix_if.red          = '0;
		pix_if.green        = '0;
		pix_if.blue         = '0;
		pix_if.window_start = 1'b0;
		for (int i = 0; i < rmwm_pkg::WIN_SIZE; i++)
			win_pred[i] = '0;
		gathered_pred = 0;
		full_grp_pred = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_column_before_full_window();
		test_full_window_max();
		test_column_flags_ignored();
		test_random_with_idling(480);
		test_output_backpressure();
		test_random_full_rate(480);
		pix_if.valid <= 1'b0;

		// drain, then a few extra cycles for anything stray
		while (filt_expected.size() > 0)
			@(posedge clk);
		repeat (LAT_CYCLES * 4) @(posedge clk);

		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
